// ----- hw/rtl/obbsat_pkg.sv -----
`default_nettype none
package obbsat_pkg;

    localparam int COORD_WIDTH_DEF = 21;
    localparam int AXIS_WIDTH_DEF  = 16;

    // Configuration port
    localparam int CFG_DATA_W = 63;
    localparam int CFG_IDX_W  = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HALF   = 3'd0,
        REG_CENTER = 3'd1,
        REG_AXIS_X = 3'd2,
        REG_AXIS_Y = 3'd3,
        REG_AXIS_Z = 3'd4
    } t_cfg_reg;

    // Per-stage load enables, grouped by the module that owns the stages
    typedef struct packed {
        logic [2:0] front;
        logic [1:0] prod;
        logic [2:0] test;
    } t_stage_en;

    localparam int N_STAGES = 8;

endpackage
`default_nettype wire

// ----- hw/rtl/obbsat_front.sv -----
`default_nettype none
module obbsat_front #(
    parameter int COORD_WIDTH = obbsat_pkg::COORD_WIDTH_DEF,
    parameter int AXIS_WIDTH  = obbsat_pkg::AXIS_WIDTH_DEF,
    localparam int CW = COORD_WIDTH,
    localparam int AW = AXIS_WIDTH,
    localparam int VW = CW + 1,
    localparam int PW = VW + AW,
    localparam int TW = PW + 2,
    localparam int RW = 2 * AW + 2,
    localparam int MW = 2 * AW
) (
    input  wire logic                 i_clk,
    input  wire logic [2:0]           i_en,
    input  wire logic signed [CW-1:0] i_c [3],
    input  wire logic [CW-2:0]        i_h [3],
    input  wire logic signed [AW-1:0] i_bax [3][3],
    input  wire logic signed [CW-1:0] i_oc [3],
    input  wire logic [CW-1:0]        i_oh [3],
    input  wire logic signed [AW-1:0] i_oax [3][3],
    output logic signed [TW-1:0]      o_t [3],
    output logic signed [RW-1:0]      o_r [3][3],
    output logic [MW-1:0]             o_m [3][3],
    output logic [CW-1:0]             o_a [3],
    output logic [CW-2:0]             o_b [3]
);

    logic signed [VW-1:0]   r_v [3];
    logic [CW-1:0]          r_a1 [3];
    logic [CW-2:0]          r_b1 [3];
    logic signed [AW-1:0]   r_bax1 [3][3];

    logic signed [PW-1:0]   r_pv [3][3];
    logic signed [MW-1:0]   r_pr [3][3][3];
    logic [CW-1:0]          r_a2 [3];
    logic [CW-2:0]          r_b2 [3];

    logic signed [RW-1:0]   n_r [3][3];

    // Center difference, latch the item
    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            for (int j = 0; j < 3; j++) begin
                r_v[j]  <= VW'(i_c[j]) - VW'(i_oc[j]);
                r_a1[j] <= i_oh[j];
                r_b1[j] <= i_h[j];
                for (int k = 0; k < 3; k++) r_bax1[j][k] <= i_bax[j][k];
            end
        end
    end

    // Component products
    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            for (int i = 0; i < 3; i++) begin
                r_a2[i] <= r_a1[i];
                r_b2[i] <= r_b1[i];
                for (int j = 0; j < 3; j++) begin
                    r_pv[i][j] <= PW'(r_v[j]) * PW'(i_oax[i][j]);
                    for (int k = 0; k < 3; k++)
                        r_pr[i][k][j] <= MW'(i_oax[i][j]) * MW'(r_bax1[k][j]);
                end
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++)
            for (int k = 0; k < 3; k++)
                n_r[i][k] = RW'(r_pr[i][k][0]) + RW'(r_pr[i][k][1]) + RW'(r_pr[i][k][2]);
    end

    // Projections T, rotation R and its magnitude
    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            for (int i = 0; i < 3; i++) begin
                o_t[i] <= TW'(r_pv[i][0]) + TW'(r_pv[i][1]) + TW'(r_pv[i][2]);
                o_a[i] <= r_a2[i];
                o_b[i] <= r_b2[i];
                for (int k = 0; k < 3; k++) begin
                    o_r[i][k] <= n_r[i][k];
                    o_m[i][k] <= n_r[i][k][RW-1] ? MW'(-n_r[i][k]) : MW'(n_r[i][k]);
                end
            end
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/obbsat_prod.sv -----
`default_nettype none
module obbsat_prod #(
    parameter int COORD_WIDTH = obbsat_pkg::COORD_WIDTH_DEF,
    parameter int AXIS_WIDTH  = obbsat_pkg::AXIS_WIDTH_DEF,
    localparam int CW  = COORD_WIDTH,
    localparam int AW  = AXIS_WIDTH,
    localparam int TW  = CW + AW + 3,
    localparam int RW  = 2 * AW + 2,
    localparam int MW  = 2 * AW,
    localparam int TL  = TW / 2,
    localparam int TH  = TW - TL,
    localparam int PLW = TL + 1 + RW,
    localparam int PHW = TH + RW,
    localparam int TRW = TW + RW,
    localparam int ARW = CW + MW,
    localparam int BRW = CW - 1 + MW
) (
    input  wire logic                 i_clk,
    input  wire logic [1:0]           i_en,
    input  wire logic signed [TW-1:0] i_t [3],
    input  wire logic signed [RW-1:0] i_r [3][3],
    input  wire logic [MW-1:0]        i_m [3][3],
    input  wire logic [CW-1:0]        i_a [3],
    input  wire logic [CW-2:0]        i_b [3],
    output logic signed [TRW-1:0]     o_tr [3][3][3],
    output logic [ARW-1:0]            o_ar [3][3][3],
    output logic [BRW-1:0]            o_br [3][3][3],
    output logic signed [TW-1:0]      o_t [3],
    output logic [CW-1:0]             o_a [3],
    output logic [CW-2:0]             o_b [3]
);

    logic signed [PLW-1:0] r_pl [3][3][3];
    logic signed [PHW-1:0] r_ph [3][3][3];
    logic [ARW-1:0]        r_ar [3][3][3];
    logic [BRW-1:0]        r_br [3][3][3];
    logic signed [TW-1:0]  r_t [3];
    logic [CW-1:0]         r_a [3];
    logic [CW-2:0]         r_b [3];

    // Split T into a low unsigned half and a signed high half
    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            for (int m = 0; m < 3; m++) begin
                r_t[m] <= i_t[m];
                r_a[m] <= i_a[m];
                r_b[m] <= i_b[m];
                for (int n = 0; n < 3; n++)
                    for (int k = 0; k < 3; k++) begin
                        r_pl[m][n][k] <= PLW'($signed({1'b0, i_t[m][TL-1:0]})) * PLW'(i_r[n][k]);
                        r_ph[m][n][k] <= PHW'($signed(i_t[m][TW-1:TL])) * PHW'(i_r[n][k]);
                        r_ar[m][n][k] <= ARW'(i_a[m]) * ARW'(i_m[n][k]);
                        r_br[m][n][k] <= BRW'(i_b[m]) * BRW'(i_m[n][k]);
                    end
            end
        end
    end

    // Recombine the partial products
    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            for (int m = 0; m < 3; m++) begin
                o_t[m] <= r_t[m];
                o_a[m] <= r_a[m];
                o_b[m] <= r_b[m];
                for (int n = 0; n < 3; n++)
                    for (int k = 0; k < 3; k++) begin
                        o_tr[m][n][k] <= (TRW'(r_ph[m][n][k]) <<< TL) + TRW'(r_pl[m][n][k]);
                        o_ar[m][n][k] <= r_ar[m][n][k];
                        o_br[m][n][k] <= r_br[m][n][k];
                    end
            end
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/obbsat_test.sv -----
`default_nettype none
module obbsat_test #(
    parameter int COORD_WIDTH = obbsat_pkg::COORD_WIDTH_DEF,
    parameter int AXIS_WIDTH  = obbsat_pkg::AXIS_WIDTH_DEF,
    localparam int CW  = COORD_WIDTH,
    localparam int AW  = AXIS_WIDTH,
    localparam int F   = AW - 2,
    localparam int TW  = CW + AW + 3,
    localparam int RW  = 2 * AW + 2,
    localparam int MW  = 2 * AW,
    localparam int TRW = TW + RW,
    localparam int ARW = CW + MW,
    localparam int BRW = CW - 1 + MW,
    localparam int SW  = CW + 3 * AW + 8,
    localparam int STW = SW + 1
) (
    input  wire logic                  i_clk,
    input  wire logic [2:0]            i_en,
    input  wire logic signed [TRW-1:0] i_tr [3][3][3],
    input  wire logic [ARW-1:0]        i_ar [3][3][3],
    input  wire logic [BRW-1:0]        i_br [3][3][3],
    input  wire logic signed [TW-1:0]  i_t [3],
    input  wire logic [CW-1:0]         i_a [3],
    input  wire logic [CW-2:0]         i_b [3],
    output logic                       o_overlap
);

    logic signed [STW-1:0] n_ts [15];
    logic [SW-1:0]         n_ra [15];
    logic [SW-1:0]         n_rb [15];
    logic signed [STW-1:0] r_ts [15];
    logic [SW-1:0]         r_ra [15];
    logic [SW-1:0]         r_rb [15];
    logic [SW-1:0]         r_tabs [15];
    logic [SW-1:0]         r_rsum [15];
    logic [14:0]           n_gt;

    always_comb begin
        int i1, i2, k1, k2, x;
        for (int i = 0; i < 3; i++) begin
            // Axes of the configured box
            n_ts[i] = STW'(i_t[i]) <<< (2 * F);
            n_ra[i] = SW'(i_a[i]) << (3 * F);
            n_rb[i] = (SW'(i_br[0][i][0]) + SW'(i_br[1][i][1]) + SW'(i_br[2][i][2])) << F;
            // Axes of the input box
            n_ts[3 + i] = STW'(i_tr[0][0][i]) + STW'(i_tr[1][1][i]) + STW'(i_tr[2][2][i]);
            n_ra[3 + i] = (SW'(i_ar[0][0][i]) + SW'(i_ar[1][1][i]) + SW'(i_ar[2][2][i])) << F;
            n_rb[3 + i] = SW'(i_b[i]) << (3 * F);
        end
        // Cross products A[i] x B[k]
        for (int i = 0; i < 3; i++) begin
            i1 = (i == 2) ? 0 : i + 1;
            i2 = (i == 0) ? 2 : i - 1;
            for (int k = 0; k < 3; k++) begin
                k1 = (k == 2) ? 0 : k + 1;
                k2 = (k == 0) ? 2 : k - 1;
                x  = 6 + 3 * i + k;
                n_ts[x] = STW'(i_tr[i2][i1][k]) - STW'(i_tr[i1][i2][k]);
                n_ra[x] = (SW'(i_ar[i1][i2][k]) + SW'(i_ar[i2][i1][k])) << F;
                n_rb[x] = (SW'(i_br[k1][i][k2]) + SW'(i_br[k2][i][k1])) << F;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            for (int x = 0; x < 15; x++) begin
                r_ts[x] <= n_ts[x];
                r_ra[x] <= n_ra[x];
                r_rb[x] <= n_rb[x];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            for (int x = 0; x < 15; x++) begin
                r_tabs[x] <= r_ts[x][STW-1] ? SW'(-r_ts[x]) : SW'(r_ts[x]);
                r_rsum[x] <= r_ra[x] + r_rb[x];
            end
        end
    end

    always_comb begin
        for (int x = 0; x < 15; x++) n_gt[x] = r_tabs[x] > r_rsum[x];
    end

    // Touching counts as overlap: only a strict excess separates
    always_ff @(posedge i_clk) begin
        if (i_en[2]) o_overlap <= ~(|n_gt);
    end

endmodule
`default_nettype wire

// ----- hw/rtl/obb_overlap_separating_axis.sv -----
`default_nettype none
// Channel    Dir  Handshake                    Payload
// s_axis     in   i_s_axis_tvalid/o_s_axis_tready   box center, half extents, three axes
// m_axis     out  o_m_axis_tvalid/i_m_axis_tready   overlap flag
// cfg        in   i_cfg_we (no wait)            register index, register value
//
// One request enters per cycle while the output is not stalled.
// The depth is set by the projection/rotation products, the wide T x R product
// split into two partial products, and the final add/abs/compare over 15 axes.
// Every stage holds its own valid bit; a stage loads when it is empty or when the
// stage after it moves, so bubbles collapse and a stalled output holds the pipe.
// Reset (synchronous, active low) clears valid bits and restores the register defaults.
module obb_overlap_separating_axis #(
    parameter int COORD_WIDTH = obbsat_pkg::COORD_WIDTH_DEF,
    parameter int AXIS_WIDTH  = obbsat_pkg::AXIS_WIDTH_DEF,
    localparam int CW  = COORD_WIDTH,
    localparam int AW  = AXIS_WIDTH,
    localparam int DW  = 6 * CW - 3 + 9 * AW,
    localparam int TDW = ((DW + 7) / 8) * 8
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_s_axis_tvalid,
    output logic                                      o_s_axis_tready,
    // center x,y,z; half x,y,z; axis first, second, third
    input  wire logic [TDW-1:0]                       i_s_axis_tdata,
    output logic                                      o_m_axis_tvalid,
    input  wire logic                                 i_m_axis_tready,
    // overlap
    output logic [7:0]                                o_m_axis_tdata,
    input  wire logic                                 i_cfg_we,
    input  wire logic [obbsat_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [obbsat_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int NS    = obbsat_pkg::N_STAGES;
    localparam int CDW   = obbsat_pkg::CFG_DATA_W;
    localparam int F     = AW - 2;
    localparam int EXC   = (3 * CW > CDW) ? 3 * CW : CDW;
    localparam int EXA   = (3 * AW > CDW) ? 3 * AW : CDW;
    localparam int OFF_H = 3 * CW;
    localparam int OFF_A = OFF_H + 3 * (CW - 1);
    localparam int TW    = CW + AW + 3;
    localparam int RW    = 2 * AW + 2;
    localparam int MW    = 2 * AW;
    localparam int TRW   = TW + RW;
    localparam int ARW   = CW + MW;
    localparam int BRW   = CW - 1 + MW;

    localparam logic [CDW-1:0] AX_X_RST = CDW'(1) << F;
    localparam logic [CDW-1:0] AX_Y_RST = CDW'(1) << (F + AW);
    localparam logic [CDW-1:0] AX_Z_RST = CDW'(1) << (F + 2 * AW);

    logic [CDW-1:0] r_half, r_center, r_axis [3];
    logic [NS-1:0]  r_vld, en;
    obbsat_pkg::t_stage_en st_en;

    logic [EXC-1:0]        half_ext, center_ext;
    logic [EXA-1:0]        axis_ext [3];
    logic signed [CW-1:0]  cfg_c [3];
    logic [CW-1:0]         cfg_h [3];
    logic signed [AW-1:0]  cfg_ax [3][3];
    logic signed [CW-1:0]  box_c [3];
    logic [CW-2:0]         box_h [3];
    logic signed [AW-1:0]  box_ax [3][3];

    logic signed [TW-1:0]  f_t [3];
    logic signed [RW-1:0]  f_r [3][3];
    logic [MW-1:0]         f_m [3][3];
    logic [CW-1:0]         f_a [3];
    logic [CW-2:0]         f_b [3];
    logic signed [TRW-1:0] p_tr [3][3][3];
    logic [ARW-1:0]        p_ar [3][3][3];
    logic [BRW-1:0]        p_br [3][3][3];
    logic signed [TW-1:0]  p_t [3];
    logic [CW-1:0]         p_a [3];
    logic [CW-2:0]         p_b [3];
    logic                  overlap;

    // Register writes; an unknown index is dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half    <= '0;
            r_center  <= '0;
            r_axis[0] <= AX_X_RST;
            r_axis[1] <= AX_Y_RST;
            r_axis[2] <= AX_Z_RST;
        end else if (i_cfg_we) begin
            unique case (obbsat_pkg::t_cfg_reg'(i_cfg_idx))
                obbsat_pkg::REG_HALF:   r_half    <= i_cfg_data;
                obbsat_pkg::REG_CENTER: r_center  <= i_cfg_data;
                obbsat_pkg::REG_AXIS_X: r_axis[0] <= i_cfg_data;
                obbsat_pkg::REG_AXIS_Y: r_axis[1] <= i_cfg_data;
                obbsat_pkg::REG_AXIS_Z: r_axis[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Unpack registers and request; fields past the register top read as zero
    always_comb begin
        half_ext   = EXC'(r_half);
        center_ext = EXC'(r_center);
        for (int i = 0; i < 3; i++) axis_ext[i] = EXA'(r_axis[i]);
        for (int j = 0; j < 3; j++) begin
            cfg_h[j] = half_ext[j*CW +: CW];
            cfg_c[j] = $signed(center_ext[j*CW +: CW]);
            box_c[j] = $signed(i_s_axis_tdata[j*CW +: CW]);
            box_h[j] = i_s_axis_tdata[OFF_H + j*(CW-1) +: CW-1];
            for (int k = 0; k < 3; k++) begin
                cfg_ax[j][k] = $signed(axis_ext[j][k*AW +: AW]);
                box_ax[j][k] = $signed(i_s_axis_tdata[OFF_A + (3*j + k)*AW +: AW]);
            end
        end
    end

    // Stage k loads when empty or when stage k+1 loads
    always_comb begin
        en[NS-1] = !r_vld[NS-1] || i_m_axis_tready;
        for (int k = NS - 2; k >= 0; k--) en[k] = !r_vld[k] || en[k+1];
    end

    assign st_en = {<<{en}};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) r_vld[0] <= i_s_axis_tvalid;
            for (int k = 1; k < NS; k++)
                if (en[k]) r_vld[k] <= r_vld[k-1];
        end
    end

    assign o_s_axis_tready = en[0];
    assign o_m_axis_tvalid = r_vld[NS-1];
    assign o_m_axis_tdata  = {7'b0, overlap};

    obbsat_front #(.COORD_WIDTH(COORD_WIDTH), .AXIS_WIDTH(AXIS_WIDTH)) u_front (
        .i_clk (i_clk),
        .i_en  ({st_en.front[0], st_en.front[1], st_en.front[2]}),
        .i_c   (box_c),
        .i_h   (box_h),
        .i_bax (box_ax),
        .i_oc  (cfg_c),
        .i_oh  (cfg_h),
        .i_oax (cfg_ax),
        .o_t   (f_t),
        .o_r   (f_r),
        .o_m   (f_m),
        .o_a   (f_a),
        .o_b   (f_b)
    );

    obbsat_prod #(.COORD_WIDTH(COORD_WIDTH), .AXIS_WIDTH(AXIS_WIDTH)) u_prod (
        .i_clk (i_clk),
        .i_en  ({st_en.prod[0], st_en.prod[1]}),
        .i_t   (f_t),
        .i_r   (f_r),
        .i_m   (f_m),
        .i_a   (f_a),
        .i_b   (f_b),
        .o_tr  (p_tr),
        .o_ar  (p_ar),
        .o_br  (p_br),
        .o_t   (p_t),
        .o_a   (p_a),
        .o_b   (p_b)
    );

    obbsat_test #(.COORD_WIDTH(COORD_WIDTH), .AXIS_WIDTH(AXIS_WIDTH)) u_test (
        .i_clk     (i_clk),
        .i_en      ({st_en.test[0], st_en.test[1], st_en.test[2]}),
        .i_tr      (p_tr),
        .i_ar      (p_ar),
        .i_br      (p_br),
        .i_t       (p_t),
        .i_a       (p_a),
        .i_b       (p_b),
        .o_overlap (overlap)
    );

endmodule
`default_nettype wire

// ----- bench/obb_overlap_separating_axis_test.sv -----
`timescale 1ns / 1ps
module obb_overlap_separating_axis_test;

    localparam int CW  = 21;
    localparam int AW  = 16;
    localparam int FR  = AW - 2;
    localparam int TDW = 272;
    localparam int ITEMS_PER_PHASE = 250;
    localparam int N_PHASES = 6;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SQUEEZE_CYCLES = 300;
    localparam int DRAIN_CYCLES = 16;
    // unused register index: writes here must be ignored
    localparam logic [obbsat_pkg::CFG_IDX_W-1:0] REG_NONE = 3'd7;
    localparam logic [AW-1:0] UNIT = 16'sd16384;

    typedef logic signed [127:0] t_wide;

    typedef struct packed {
        logic [2:0][47:0]   ax;   // B axes, first in the low bits
        logic [2:0][19:0]   h;    // half extents
        logic [2:0][CW-1:0] c;    // signed center coordinates
    } t_box;

    typedef struct {
        t_box box;
        int   pinned;             // -1: use the predictor, else the known flag
    } t_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_s_axis_tvalid = 1'b0;
    logic                 o_s_axis_tready;
    logic [TDW-1:0]       i_s_axis_tdata = '0;
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready = 1'b0;
    logic [7:0]           o_m_axis_tdata;
    logic                 i_cfg_we = 1'b0;
    logic [obbsat_pkg::CFG_IDX_W-1:0] i_cfg_idx = obbsat_pkg::REG_HALF;
    logic [obbsat_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    // Shadow copy of the configuration the predictor works from
    logic [62:0] cfg_half = '0;
    logic [62:0] cfg_center = '0;
    logic [2:0][47:0] cfg_axis;

    bit   expected_overlap[$];
    int   pinned_q[$];
    int   failures = 0;
    int   idle_cycles = 0;
    int   send_gap_pct = 0;
    int   stall_pct = 0;
    int   squeeze_req = 0;
    int   squeeze_ack = 0;
    int   hold_left = 0;

    obb_overlap_separating_axis i_dut (
        .i_clk, .i_rst_n,
        .i_s_axis_tvalid, .o_s_axis_tready, .i_s_axis_tdata,
        .o_m_axis_tvalid, .i_m_axis_tready, .o_m_axis_tdata,
        .i_cfg_we, .i_cfg_idx, .i_cfg_data
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic t_wide wmul(longint x, longint y);
        t_wide p, q;
        p = x;
        q = y;
        return p * q;
    endfunction

    function automatic t_wide wabs(t_wide x);
        return (x < 0) ? -x : x;
    endfunction

    function automatic longint lmag(longint x);
        return (x < 0) ? -x : x;
    endfunction

    // Separating-axis test over all 15 axes; any strict gap means disjoint
    function automatic bit predict_overlap(t_box b);
        longint v[3], ha[3], hb[3], tp[3], rm[3][3], ca[3][3], cb[3][3];
        t_wide  t, ra, rb;
        bit     sep;
        int     i1, i2, k1, k2;
        sep = 1'b0;
        for (int j = 0; j < 3; j++) begin
            v[j]  = longint'($signed(b.c[j])) - longint'($signed(cfg_center[CW*j +: CW]));
            ha[j] = longint'(cfg_half[CW*j +: CW]);
            hb[j] = longint'(b.h[j]);
        end
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                ca[i][j] = longint'($signed(cfg_axis[i][AW*j +: AW]));
                cb[i][j] = longint'($signed(b.ax[i][AW*j +: AW]));
            end
        end
        for (int i = 0; i < 3; i++) begin
            tp[i] = v[0] * ca[i][0] + v[1] * ca[i][1] + v[2] * ca[i][2];
            for (int k = 0; k < 3; k++) begin
                rm[i][k] = ca[i][0] * cb[k][0] + ca[i][1] * cb[k][1] + ca[i][2] * cb[k][2];
            end
        end
        // configured box axes
        for (int i = 0; i < 3; i++) begin
            t  = wabs(wmul(tp[i], 1)) <<< (2 * FR);
            ra = wmul(ha[i], 1) <<< (3 * FR);
            rb = (wmul(hb[0], lmag(rm[i][0])) + wmul(hb[1], lmag(rm[i][1]))
                  + wmul(hb[2], lmag(rm[i][2]))) <<< FR;
            if (t > ra + rb) sep = 1'b1;
        end
        // input box axes
        for (int k = 0; k < 3; k++) begin
            t  = wabs(wmul(tp[0], rm[0][k]) + wmul(tp[1], rm[1][k]) + wmul(tp[2], rm[2][k]));
            ra = (wmul(ha[0], lmag(rm[0][k])) + wmul(ha[1], lmag(rm[1][k]))
                  + wmul(ha[2], lmag(rm[2][k]))) <<< FR;
            rb = wmul(hb[k], 1) <<< (3 * FR);
            if (t > ra + rb) sep = 1'b1;
        end
        // cross products of the two axis sets
        for (int i = 0; i < 3; i++) begin
            i1 = (i + 1) % 3;
            i2 = (i + 2) % 3;
            for (int k = 0; k < 3; k++) begin
                k1 = (k + 1) % 3;
                k2 = (k + 2) % 3;
                ra = (wmul(ha[i1], lmag(rm[i2][k])) + wmul(ha[i2], lmag(rm[i1][k]))) <<< FR;
                rb = (wmul(hb[k1], lmag(rm[i][k2])) + wmul(hb[k2], lmag(rm[i][k1]))) <<< FR;
                t  = wabs(wmul(tp[i2], rm[i1][k]) - wmul(tp[i1], rm[i2][k]));
                if (t > ra + rb) sep = 1'b1;
            end
        end
        return !sep;
    endfunction

    // Signed unit vector along component n
    function automatic logic [47:0] unit_axis(int n, bit neg);
        logic [47:0] a;
        a = '0;
        a[AW*n +: AW] = neg ? -UNIT : UNIT;
        return a;
    endfunction

    // Mostly rotated unit frames near the configured box so that both outcomes occur;
    // the rest is raw bits over the whole field range.
    function automatic t_box make_box();
        t_box b;
        int   rot;
        if ($urandom_range(99) < 30) begin
            for (int j = 0; j < 3; j++) begin
                b.c[j]  = CW'($urandom);
                b.h[j]  = 20'($urandom);
                b.ax[j] = 48'({$urandom, $urandom});
            end
        end else begin
            rot = $urandom_range(2);
            for (int j = 0; j < 3; j++) begin
                b.c[j] = cfg_center[CW*j +: CW] + CW'($urandom_range(4096)) - CW'(2048);
                b.h[j] = 20'($urandom_range(1500));
                if ($urandom_range(3) == 0) begin
                    b.ax[j] = {AW'($urandom_range(32767)) - AW'(16384),
                               AW'($urandom_range(32767)) - AW'(16384),
                               AW'($urandom_range(32767)) - AW'(16384)};
                end else begin
                    b.ax[j] = unit_axis((j + rot) % 3, 1'($urandom_range(1)));
                end
            end
        end
        return b;
    endfunction

    // Drive one write; the caller drops the write enable after its last write
    task automatic write_reg(logic [obbsat_pkg::CFG_IDX_W-1:0] idx, logic [62:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            obbsat_pkg::REG_HALF:   cfg_half = val;
            obbsat_pkg::REG_CENTER: cfg_center = val;
            obbsat_pkg::REG_AXIS_X: cfg_axis[0] = val[47:0];
            obbsat_pkg::REG_AXIS_Y: cfg_axis[1] = val[47:0];
            obbsat_pkg::REG_AXIS_Z: cfg_axis[2] = val[47:0];
            default: ;
        endcase
    endtask

    // Wait until the pipe has drained before touching the registers
    task automatic wait_idle();
        @(posedge i_clk);
        while (expected_overlap.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic configure(int phase);
        logic [62:0] hv, cv;
        logic [2:0][47:0] av;
        int rot;
        case (phase)
            1: begin
                // zero halves, every center at -1, all-ones axes
                hv = '0;
                cv = '1;
                av = '1;
            end
            2: begin
                // largest halves and centers, axes at the most negative component
                hv = '1;
                cv = {1'b0, 21'h0FFFFF, 21'h0FFFFF, 21'h0FFFFF};
                av = {3{48'h8000_8000_8000}};
            end
            5: begin
                hv = 63'({$urandom, $urandom});
                cv = 63'({$urandom, $urandom});
                av = 144'({$urandom, $urandom, $urandom, $urandom, $urandom});
            end
            default: begin
                rot = $urandom_range(2);
                for (int j = 0; j < 3; j++) begin
                    hv[CW*j +: CW] = CW'($urandom_range(2000));
                    cv[CW*j +: CW] = CW'($urandom_range(200000)) - CW'(100000);
                    av[j] = unit_axis((j + rot) % 3, 1'($urandom_range(1)));
                end
            end
        endcase
        write_reg(obbsat_pkg::REG_HALF, hv);
        write_reg(obbsat_pkg::REG_CENTER, cv);
        write_reg(obbsat_pkg::REG_AXIS_X, {15'd0, av[0]});
        write_reg(obbsat_pkg::REG_AXIS_Y, {15'd0, av[1]});
        write_reg(obbsat_pkg::REG_AXIS_Z, {15'd0, av[2]});
        write_reg(REG_NONE, 63'({$urandom, $urandom}));
        i_cfg_we <= 1'b0;
    endtask

    // Offer one request, with an optional gap in front; hold valid across back-to-back requests
    task automatic send_box(t_box b, int pinned);
        if (send_gap_pct > 0 && $urandom_range(99) < send_gap_pct) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        pinned_q.push_back(pinned);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= TDW'({b.ax, b.h, b.c});
        do @(posedge i_clk); while (!o_s_axis_tready);
    endtask

    function automatic t_box box_of(logic signed [CW-1:0] c, logic [19:0] h, logic [47:0] a0,
                                    logic [47:0] a1, logic [47:0] a2);
        t_box b;
        b.c  = {c, c, c};
        b.h  = {h, h, h};
        b.ax = {a2, a1, a0};
        return b;
    endfunction

    // Receiver: random stalls, plus a long hold-off on request to back up the pipe
    always @(posedge i_clk) begin
        if (squeeze_req != squeeze_ack) begin
            squeeze_ack = squeeze_req;
            hold_left = SQUEEZE_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Monitor: predict on every accepted request, check every accepted result
    always @(posedge i_clk) begin
        bit moved;
        bit want;
        int pin;
        t_box b;
        moved = 1'b0;
        if (i_rst_n && i_s_axis_tvalid && o_s_axis_tready) begin
            b = t_box'(i_s_axis_tdata[$bits(t_box)-1:0]);
            pin = pinned_q.pop_front();
            expected_overlap.push_back(pin < 0 ? predict_overlap(b) : bit'(pin));
            moved = 1'b1;
        end
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            moved = 1'b1;
            if (expected_overlap.size() == 0) begin
                $error("overlap: result with no request outstanding, got %0d",
                       o_m_axis_tdata[0]);
                failures++;
            end else begin
                want = expected_overlap.pop_front();
                if (o_m_axis_tdata[0] !== want) begin
                    $error("overlap: expected %0d, actual %0d", want, o_m_axis_tdata[0]);
                    failures++;
                end
            end
        end
        idle_cycles = moved ? 0 : idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("obb_overlap_separating_axis verification failed");
            $finish;
        end
    end

    initial begin
        t_row rows[$];
        logic [47:0] ex, ey, ez;
        ex = unit_axis(0, 1'b0);
        ey = unit_axis(1, 1'b0);
        ez = unit_axis(2, 1'b0);
        cfg_axis = {ez, ey, ex};

        // Directed rows, run against the reset configuration (unit frame at the origin)
        rows.push_back('{box_of(21'sd0, 20'd0, '0, '0, '0), 1});
        rows.push_back('{box_of(21'sh0FFFFF, 20'd0, '0, '0, '0), 0});
        rows.push_back('{box_of(-21'sh100000, 20'd0, '0, '0, '0), 0});
        rows.push_back('{box_of(-21'sh100000, 20'd0, ex, ey, ez), 0});
        rows.push_back('{box_of(21'sd0, 20'hFFFFF, ex, ey, ez), 1});
        rows.push_back('{box_of(21'sd0, 20'hFFFFF, '1, '1, '1), 1});
        rows.push_back('{box_of(21'sh0FFFFF, 20'hFFFFF, '1, '1, '1), -1});
        rows.push_back('{box_of(21'sh0FFFFF, 20'hFFFFF, 48'h8000_8000_8000,
                                48'h8000_8000_8000, 48'h8000_8000_8000), -1});
        rows.push_back('{box_of(21'sh0FFFFF, 20'h80000, ey, ez, ex), -1});
        // touching faces, then one step apart
        rows.push_back('{box_of(21'sd256, 20'd256, ex, ey, ez), -1});
        rows.push_back('{box_of(21'sd257, 20'd256, ex, ey, ez), -1});
        rows[9].box.c[1] = '0;
        rows[9].box.c[2] = '0;
        rows[10].box.c[1] = '0;
        rows[10].box.c[2] = '0;
        rows[10].box.h = {20'd256, 20'd256, 20'd256};
        // skewed, non-unit axes
        rows.push_back('{box_of(21'sd300, 20'd100, 48'h0000_2000_2000,
                                48'h0000_2000_E000, 48'h4000_0000_0000), -1});
        rows.push_back('{box_of(-21'sd700, 20'd500, 48'h1000_3000_0800,
                                48'h7FFF_0001_FFFF, 48'h0123_4567_89AB), -1});

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int p = 0; p < N_PHASES; p++) begin
            if (p > 0) begin
                wait_idle();
                configure(p);
            end
            // cycle the idle pattern: none, sender gaps, receiver stalls, both
            case (p % 4)
                0: begin send_gap_pct = 0;  stall_pct = 0;  end
                1: begin send_gap_pct = 46; stall_pct = 0;  end
                2: begin send_gap_pct = 0;  stall_pct = 46; end
                default: begin send_gap_pct = 14; stall_pct = 14; end
            endcase
            if (p == 0) begin
                foreach (rows[r]) send_box(rows[r].box, rows[r].pinned);
            end
            if (p == 1) squeeze_req++;
            for (int n = 0; n < ITEMS_PER_PHASE; n++) send_box(make_box(), -1);
            i_s_axis_tvalid <= 1'b0;
        end

        wait_idle();
        if (failures == 0) begin
            $display("obb_overlap_separating_axis verification clean");
        end else begin
            $display("obb_overlap_separating_axis verification failed");
        end
        $finish;
    end
endmodule
